// ===== rtl/sfp_pkg.sv =====
// ---------------------------------------------------------------------------
// sfp_pkg: shared types and constants for the sensor frame parser
// Frame delimiters, word/cmd codes, parser phases, error codes and the
// layout of the result word.
// ---------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    // Frame delimiters
    localparam logic [7:0] HDR_FIRST  = 8'h53;
    localparam logic [7:0] HDR_SECOND = 8'h59;
    localparam logic [7:0] TRL_FIRST  = 8'h54;
    localparam logic [7:0] TRL_SECOND = 8'h43;

    // Word and cmd codes
    localparam logic [7:0] WORD_KEEPALIVE = 8'h80;
    localparam logic [7:0] WORD_PRESENCE  = 8'h01;
    localparam logic [7:0] WORD_BREATH    = 8'h02;
    localparam logic [7:0] WORD_HEART     = 8'h03;
    localparam logic [7:0] CMD_PHASE      = 8'h01;
    localparam logic [7:0] CMD_RATE       = 8'h05;

    // Received flag bits
    localparam int FLAG_PRESENCE = 0;
    localparam int FLAG_BREATH   = 1;
    localparam int FLAG_HEART    = 2;
    localparam logic [2:0] FLAGS_ALL = 3'b111;

    // Input request kinds (tuser)
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR  = 3'd0,
        PH_WORD = 3'd1,
        PH_CMD  = 3'd2,
        PH_LENL = 3'd3,
        PH_LENH = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6,
        PH_TAIL = 3'd7
    } phase_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_CHECKSUM = 2'd2,
        ERR_TRAILER  = 2'd3
    } err_t;

    // Result word, lowest field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic       window_complete;
        err_t       error_code;
        logic       frame_accepted;
        logic [2:0] received_flags;
        logic [7:0] heartbeat_rate;
        logic [7:0] heart_phase;
        logic [15:0] breath_rate;
        logic [7:0] breath_phase;
        logic [7:0] presence_byte;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== rtl/sensor_frame_parser.sv =====
// ---------------------------------------------------------------------------
// sensor_frame_parser: byte-serial sensor frame parser
// Parses header, word, cmd, length, payload, XOR checksum and trailer one
// byte per request and keeps the latest presence and vital-sign values.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata = rx_byte, tuser = cmd
//  m_axis   | out | m_axis_tvalid/tready   | tdata = result word (56 bits)
//
//  One request in, one result out; a request is taken every cycle unless the result register is full and stalled.
//  The parser state and the result register update at the edge that takes the request.
//  The single result register decouples the sides: a request is taken while
//  the register is empty or its result is taken in the same cycle.
//  rst_n clears the parser, held values, flags and the result valid.
// ---------------------------------------------------------------------------
`default_nettype none

module sensor_frame_parser
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]          s_axis_tuser,   // [0] cmd
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [7:0] presence byte, [15:8] breathing phase,
    // [31:16] breathing rate (tenths), [39:32] heartbeat phase,
    // [47:40] heartbeat_rate, [50:48] received_flags, [51] frame_accepted,
    // [53:52] error_code, [54] window_complete, [55] zero
    output logic [RESULT_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

    // Parser state
    phase_t           phase_reg, phase_next;
    logic             hdr_half_reg, hdr_half_next;
    logic             trl_half_reg, trl_half_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       subkind_reg, subkind_next;
    logic [7:0]       len_low_reg, len_low_next;
    logic [IDX_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       pay0_reg, pay0_next;
    logic [7:0]       pay1_reg, pay1_next;

    // Held values
    logic [7:0]       presence_reg, presence_next;
    logic [7:0]       bphase_reg, bphase_next;
    logic [15:0]      brate_reg, brate_next;
    logic [7:0]       hphase_reg, hphase_next;
    logic [7:0]       hrate_reg, hrate_next;
    logic [2:0]       flags_reg, flags_next;
    logic             done_reg, done_next;

    // Output stage
    logic             out_valid_reg;
    result_t          out_data_reg;
    result_t          result_next;

    logic             take;
    logic [7:0]       b;
    logic [15:0]      len_full;
    logic [IDX_W-1:0] idx_inc;
    logic [2:0]       flags_upd;
    logic             accepted;
    err_t             err;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign len_full      = {b, len_low_reg};
    assign idx_inc       = idx_reg + IDX_W'(1);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            hdr_half_reg <= 1'b0;
            trl_half_reg <= 1'b0;
            kind_reg     <= '0;
            subkind_reg  <= '0;
            len_low_reg  <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
            xor_reg      <= '0;
            presence_reg <= '0;
            bphase_reg   <= '0;
            brate_reg    <= '0;
            hphase_reg   <= '0;
            hrate_reg    <= '0;
            flags_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_half_reg <= hdr_half_next;
            trl_half_reg <= trl_half_next;
            kind_reg     <= kind_next;
            subkind_reg  <= subkind_next;
            len_low_reg  <= len_low_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            xor_reg      <= xor_next;
            presence_reg <= presence_next;
            bphase_reg   <= bphase_next;
            brate_reg    <= brate_next;
            hphase_reg   <= hphase_next;
            hrate_reg    <= hrate_next;
            flags_reg    <= flags_next;
            done_reg     <= done_next;
        end
    end

    // Payload bytes: only the first two are ever used
    always_ff @(posedge clk)
    begin
        pay0_reg <= pay0_next;
        pay1_reg <= pay1_next;
    end

    // Next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_half_next = hdr_half_reg;
        trl_half_next = trl_half_reg;
        kind_next     = kind_reg;
        subkind_next  = subkind_reg;
        len_low_next  = len_low_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        xor_next      = xor_reg;
        pay0_next     = pay0_reg;
        pay1_next     = pay1_reg;
        presence_next = presence_reg;
        bphase_next   = bphase_reg;
        brate_next    = brate_reg;
        hphase_next   = hphase_reg;
        hrate_next    = hrate_reg;
        flags_next    = flags_reg;
        done_next     = done_reg;
        flags_upd     = flags_reg;
        accepted      = 1'b0;
        err           = ERR_NONE;

        if (take)
        begin
            if (s_axis_tuser[0] == CMD_START)
            begin
                // New window: clear flags and parser, keep held values
                flags_next    = '0;
                done_next     = 1'b0;
                phase_next    = PH_HDR;
                hdr_half_next = 1'b0;
                trl_half_next = 1'b0;
                xor_next      = '0;
                idx_next      = '0;
            end
            else if (!done_reg)
            begin
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (hdr_half_reg && b == HDR_SECOND)
                        begin
                            hdr_half_next = 1'b0;
                            xor_next      = '0;
                            phase_next    = PH_WORD;
                        end
                        else
                        begin
                            // a stray first header byte re-arms the match
                            hdr_half_next = (b == HDR_FIRST);
                        end
                    end
                    PH_WORD:
                    begin
                        kind_next  = b;
                        xor_next   = xor_reg ^ b;
                        phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        subkind_next = b;
                        xor_next     = xor_reg ^ b;
                        phase_next   = PH_LENL;
                    end
                    PH_LENL:
                    begin
                        len_low_next = b;
                        xor_next     = xor_reg ^ b;
                        phase_next   = PH_LENH;
                    end
                    PH_LENH:
                    begin
                        xor_next = xor_reg ^ b;
                        idx_next = '0;
                        len_next = len_low_reg[IDX_W-1:0];
                        if (len_full > 16'(MAX_PAYLOAD))
                        begin
                            err        = ERR_LENGTH;
                            phase_next = PH_HDR;
                            xor_next   = '0;
                        end
                        else if (len_full == 16'd0)
                        begin
                            phase_next = PH_SUM;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (idx_reg == IDX_W'(0))
                        begin
                            pay0_next = b;
                        end
                        if (idx_reg == IDX_W'(1))
                        begin
                            pay1_next = b;
                        end
                        idx_next = idx_inc;
                        xor_next = xor_reg ^ b;
                        if (idx_inc >= len_reg)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        if (b != xor_reg)
                        begin
                            err        = ERR_CHECKSUM;
                            phase_next = PH_HDR;
                            xor_next   = '0;
                            idx_next   = '0;
                        end
                        else
                        begin
                            trl_half_next = 1'b0;
                            phase_next    = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        if (!trl_half_reg && b == TRL_FIRST)
                        begin
                            trl_half_next = 1'b1;
                        end
                        else if (trl_half_reg && b == TRL_SECOND)
                        begin
                            // complete frame: apply the known word/cmd pairs
                            accepted = 1'b1;
                            if (kind_reg == WORD_KEEPALIVE && subkind_reg == CMD_PHASE)
                            begin
                                flags_upd = flags_reg;
                            end
                            else if (kind_reg == WORD_PRESENCE && subkind_reg == CMD_PHASE
                                     && len_reg != '0)
                            begin
                                presence_next            = pay0_reg;
                                flags_upd[FLAG_PRESENCE] = 1'b1;
                            end
                            else if (kind_reg == WORD_BREATH && subkind_reg == CMD_PHASE
                                     && len_reg != '0)
                            begin
                                bphase_next = pay0_reg;
                            end
                            else if (kind_reg == WORD_BREATH && subkind_reg == CMD_RATE
                                     && len_reg >= IDX_W'(2))
                            begin
                                brate_next             = {pay1_reg, pay0_reg};
                                flags_upd[FLAG_BREATH] = 1'b1;
                            end
                            else if (kind_reg == WORD_HEART && subkind_reg == CMD_PHASE
                                     && len_reg != '0)
                            begin
                                hphase_next = pay0_reg;
                            end
                            else if (kind_reg == WORD_HEART && subkind_reg == CMD_RATE
                                     && len_reg != '0)
                            begin
                                hrate_next            = pay0_reg;
                                flags_upd[FLAG_HEART] = 1'b1;
                            end
                            flags_next    = flags_upd;
                            done_next     = (flags_upd == FLAGS_ALL);
                            phase_next    = PH_HDR;
                            trl_half_next = 1'b0;
                            xor_next      = '0;
                            idx_next      = '0;
                        end
                        else
                        begin
                            err           = ERR_TRAILER;
                            phase_next    = PH_HDR;
                            trl_half_next = 1'b0;
                            xor_next      = '0;
                            idx_next      = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HDR;
                    end
                endcase
            end
        end

        result_next.pad             = 1'b0;
        result_next.window_complete = done_next;
        result_next.error_code      = err;
        result_next.frame_accepted  = accepted;
        result_next.received_flags  = flags_next;
        result_next.heartbeat_rate  = hrate_next;
        result_next.heart_phase     = hphase_next;
        result_next.breath_rate     = brate_next;
        result_next.breath_phase    = bphase_next;
        result_next.presence_byte   = presence_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_parser_checker.sv =====
// ---------------------------------------------------------------------------
// sensor_frame_parser_checker: port-level checks for the frame parser
// Watches the stream ports and checks handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module sensor_frame_parser_checker
    import sfp_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [0:0]          s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [RESULT_W-1:0] m_axis_tdata
);

    result_t res;

    assign res = m_axis_tdata;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // An empty result register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // A frame cannot be both accepted and in error
    a_acc_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.frame_accepted && res.error_code != ERR_NONE))
        else $error("frame accepted with an error code");

    // A complete window has all three flags set
    a_window_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.window_complete |-> res.received_flags == FLAGS_ALL)
        else $error("window complete without all flags");

    // A start-window request gives a cleared, error-free result
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_START
        |=> res.received_flags == 3'b000 && !res.window_complete
            && !res.frame_accepted && res.error_code == ERR_NONE)
        else $error("start window did not clear the result");

endmodule

bind sensor_frame_parser sensor_frame_parser_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_sensor_frame_parser.sv =====
// ---------------------------------------------------------------------------
// tb_sensor_frame_parser: self-checking testbench for the sensor frame parser
// Drives received bytes and start-window requests through the input stream,
// predicts every result word with its own byte-serial parser and compares
// the output stream field by field. A short directed table comes first, then
// randomised frames with random corruption, noise and window restarts, with
// random gaps on both sides and one long output stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sensor_frame_parser;

    import sfp_pkg::*;

    localparam int MAX_PAYLOAD  = 4;
    localparam int PAY_IDX_W    = $clog2(MAX_PAYLOAD);
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;

    // Directed table row: pinned rows carry the typed-in accept and error code
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       pin;
        logic       acc;
        err_t       err;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic [0:0]          s_axis_tuser = 1'b0;    // [0] cmd
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] m_axis_tdata;           // result_t, presence byte lowest

    // Predictor state
    phase_t      phase_now;
    logic        hdr_armed;
    logic        trl_armed;
    logic [7:0]  rx_word;
    logic [7:0]  rx_sub;
    logic [15:0] rx_len;
    int          pay_idx;
    logic [7:0]  xor_acc;
    logic [7:0]  pay_bytes [MAX_PAYLOAD];
    logic [7:0]  held_presence;
    logic [7:0]  held_breath_phase;
    logic [15:0] held_breath_rate;
    logic [7:0]  held_heart_phase;
    logic [7:0]  held_heart_rate;
    logic [2:0]  seen_mask;
    logic        window_full;

    result_t     expected_results [$];
    int          error_count = 0;
    int          live_items = 0;
    int          results_seen = 0;
    int          send_calm = 0;
    int          recv_calm = 0;

    stim_row_t directed_rows [24] = '{
        // start window straight after reset
        '{CMD_START, 8'hA5, 1'b1, 1'b0, ERR_NONE},
        // stray header byte, then the largest length
        '{CMD_BYTE, HDR_FIRST,  1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, HDR_FIRST,  1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, HDR_SECOND, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'hFF, 1'b1, 1'b0, ERR_LENGTH},
        // zero length, wrong checksum
        '{CMD_BYTE, HDR_FIRST,  1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, HDR_SECOND, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h00, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h00, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h00, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h00, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'hFF, 1'b1, 1'b0, ERR_CHECKSUM},
        // keep-alive with a broken second trailer byte
        '{CMD_BYTE, HDR_FIRST,      1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, HDR_SECOND,     1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, WORD_KEEPALIVE, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, CMD_PHASE,      1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h00, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h00, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, 8'h81, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, TRL_FIRST, 1'b0, 1'b0, ERR_NONE},
        '{CMD_BYTE, TRL_FIRST, 1'b1, 1'b0, ERR_TRAILER}
    };

    sensor_frame_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    // Random wait length per request, with occasional stretches of none
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic void clear_parser();
        phase_now = PH_HDR;
        hdr_armed = 1'b0;
        trl_armed = 1'b0;
        rx_word   = 8'h00;
        rx_sub    = 8'h00;
        rx_len    = 16'h0000;
        pay_idx   = 0;
        xor_acc   = 8'h00;
    endfunction

    // Predict the result of one request and advance the parser state
    function automatic result_t parse_request(input logic kind, input logic [7:0] b);
        result_t r;
        logic    acc;
        err_t    err;
        acc = 1'b0;
        err = ERR_NONE;
        if (kind == CMD_START)
        begin
            seen_mask   = 3'b000;
            window_full = 1'b0;
            clear_parser();
        end
        else if (!window_full)
        begin
            case (phase_now)
                PH_HDR:
                begin
                    if (!hdr_armed)
                        hdr_armed = (b == HDR_FIRST);
                    else if (b == HDR_SECOND)
                    begin
                        hdr_armed = 1'b0;
                        xor_acc   = 8'h00;
                        phase_now = PH_WORD;
                    end
                    else
                        hdr_armed = (b == HDR_FIRST);
                end
                PH_WORD:
                begin
                    rx_word   = b;
                    xor_acc  ^= b;
                    phase_now = PH_CMD;
                end
                PH_CMD:
                begin
                    rx_sub    = b;
                    xor_acc  ^= b;
                    phase_now = PH_LENL;
                end
                PH_LENL:
                begin
                    rx_len    = {8'h00, b};
                    xor_acc  ^= b;
                    phase_now = PH_LENH;
                end
                PH_LENH:
                begin
                    rx_len    = {b, rx_len[7:0]};
                    xor_acc  ^= b;
                    pay_idx   = 0;
                    if (rx_len > 16'(MAX_PAYLOAD))
                    begin
                        clear_parser();
                        err = ERR_LENGTH;
                    end
                    else if (rx_len == 16'h0000)
                        phase_now = PH_SUM;
                    else
                        phase_now = PH_DATA;
                end
                PH_DATA:
                begin
                    if (pay_idx < MAX_PAYLOAD)
                        pay_bytes[pay_idx[PAY_IDX_W-1:0]] = b;
                    pay_idx++;
                    xor_acc ^= b;
                    if (pay_idx >= int'(rx_len))
                        phase_now = PH_SUM;
                end
                PH_SUM:
                begin
                    if (b != xor_acc)
                    begin
                        clear_parser();
                        err = ERR_CHECKSUM;
                    end
                    else
                    begin
                        trl_armed = 1'b0;
                        phase_now = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    if (!trl_armed)
                    begin
                        if (b != TRL_FIRST)
                        begin
                            clear_parser();
                            err = ERR_TRAILER;
                        end
                        else
                            trl_armed = 1'b1;
                    end
                    else if (b != TRL_SECOND)
                    begin
                        clear_parser();
                        err = ERR_TRAILER;
                    end
                    else
                    begin
                        // keep-alive, short payloads and unknown pairs change nothing
                        if (rx_word == WORD_KEEPALIVE && rx_sub == CMD_PHASE)
                            ;
                        else if (rx_word == WORD_PRESENCE && rx_sub == CMD_PHASE
                                 && rx_len >= 16'd1)
                        begin
                            held_presence = pay_bytes[0];
                            seen_mask[FLAG_PRESENCE] = 1'b1;
                        end
                        else if (rx_word == WORD_BREATH && rx_sub == CMD_PHASE
                                 && rx_len >= 16'd1)
                            held_breath_phase = pay_bytes[0];
                        else if (rx_word == WORD_BREATH && rx_sub == CMD_RATE
                                 && rx_len >= 16'd2)
                        begin
                            held_breath_rate = {pay_bytes[1], pay_bytes[0]};
                            seen_mask[FLAG_BREATH] = 1'b1;
                        end
                        else if (rx_word == WORD_HEART && rx_sub == CMD_PHASE
                                 && rx_len >= 16'd1)
                            held_heart_phase = pay_bytes[0];
                        else if (rx_word == WORD_HEART && rx_sub == CMD_RATE
                                 && rx_len >= 16'd1)
                        begin
                            held_heart_rate = pay_bytes[0];
                            seen_mask[FLAG_HEART] = 1'b1;
                        end
                        clear_parser();
                        acc = 1'b1;
                        if (seen_mask == FLAGS_ALL)
                            window_full = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.pad             = 1'b0;
        r.window_complete = window_full;
        r.error_code      = err;
        r.frame_accepted  = acc;
        r.received_flags  = seen_mask;
        r.heartbeat_rate  = held_heart_rate;
        r.heart_phase     = held_heart_phase;
        r.breath_rate     = held_breath_rate;
        r.breath_phase    = held_breath_phase;
        r.presence_byte   = held_presence;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on result %0d, %s: got %h, want %h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Offer one request; enters and leaves at a falling edge
    task automatic push_request(input logic kind, input logic [7:0] b, input logic pin,
                                input logic acc, input err_t err);
        int      gap;
        result_t want;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // ignored bytes in a complete window do not count towards the total
        if (kind == CMD_START || !window_full)
            live_items++;
        want = parse_request(kind, b);
        if (pin)
        begin
            want.frame_accepted = acc;
            want.error_code     = err;
        end
        expected_results.push_back(want);
        @(negedge clk);
    endtask

    // One frame with random content, sometimes noisy, damaged or cut short
    task automatic send_frame();
        logic [7:0]  fr [$];
        logic [7:0]  word;
        logic [7:0]  sub;
        logic [7:0]  sum;
        logic [15:0] len;
        int          n;
        int          fault;
        int          keep;
        case ($urandom_range(0, 7))
            0: begin word = WORD_PRESENCE;  sub = CMD_PHASE; end
            1: begin word = WORD_BREATH;    sub = CMD_PHASE; end
            2: begin word = WORD_BREATH;    sub = CMD_RATE;  end
            3: begin word = WORD_HEART;     sub = CMD_PHASE; end
            4: begin word = WORD_HEART;     sub = CMD_RATE;  end
            5: begin word = WORD_KEEPALIVE; sub = CMD_PHASE; end
            6: begin word = 8'($urandom_range(0, 3)); sub = 8'($urandom_range(0, 7)); end
            default: begin word = 8'($urandom); sub = 8'($urandom); end
        endcase
        if ($urandom_range(0, 4) == 0)
            n = $urandom_range(0, MAX_PAYLOAD);
        else
            n = $urandom_range(2, MAX_PAYLOAD);
        len   = 16'(n);
        fault = $urandom_range(0, 99);
        if (fault < 6)
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                               : 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
        // leading noise and stray header bytes
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom));
        if ($urandom_range(0, 4) == 0)
            fr.push_back(HDR_FIRST);
        fr.push_back(HDR_FIRST);
        fr.push_back(HDR_SECOND);
        fr.push_back(word);
        fr.push_back(sub);
        fr.push_back(len[7:0]);
        fr.push_back(len[15:8]);
        sum = word ^ sub ^ len[7:0] ^ len[15:8];
        repeat (n)
        begin
            fr.push_back(8'($urandom));
            sum ^= fr[$];
        end
        if (fault >= 6 && fault < 14)
            sum ^= 8'($urandom_range(1, 255));
        fr.push_back(sum);
        fr.push_back((fault >= 14 && fault < 19) ? TRL_FIRST ^ 8'($urandom_range(1, 255))
                                                  : TRL_FIRST);
        fr.push_back((fault >= 19 && fault < 24) ? TRL_SECOND ^ 8'($urandom_range(1, 255))
                                                  : TRL_SECOND);
        // cut short: the next frame's bytes land mid-parse
        if (fault >= 24 && fault < 28)
        begin
            keep = $urandom_range(1, fr.size() - 1);
            while (fr.size() > keep)
                void'(fr.pop_back());
        end
        foreach (fr[i])
            push_request(CMD_BYTE, fr[i], 1'b0, 1'b0, ERR_NONE);
    endtask

    // Output side: random stalls, one long hold-off, field-by-field check
    initial
    begin
        int      stall;
        result_t got;
        result_t want;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = (results_seen == HOLD_AT) ? HOLD_CYCLES : draw_wait(recv_calm);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = result_t'(m_axis_tdata);
            if (expected_results.size() == 0)
                report_mismatch("no result expected", got[15:0], 16'h0000);
            else
            begin
                want = expected_results.pop_front();
                if (got.presence_byte != want.presence_byte)
                    report_mismatch("presence byte", 16'(got.presence_byte),
                                    16'(want.presence_byte));
                if (got.breath_phase != want.breath_phase)
                    report_mismatch("breath phase", 16'(got.breath_phase),
                                    16'(want.breath_phase));
                if (got.breath_rate != want.breath_rate)
                    report_mismatch("breath rate", got.breath_rate,
                                    want.breath_rate);
                if (got.heart_phase != want.heart_phase)
                    report_mismatch("heart phase", 16'(got.heart_phase),
                                    16'(want.heart_phase));
                if (got.heartbeat_rate != want.heartbeat_rate)
                    report_mismatch("heartbeat_rate", 16'(got.heartbeat_rate),
                                    16'(want.heartbeat_rate));
                if (got.received_flags != want.received_flags)
                    report_mismatch("received_flags", 16'(got.received_flags),
                                    16'(want.received_flags));
                if (got.frame_accepted != want.frame_accepted)
                    report_mismatch("frame_accepted", 16'(got.frame_accepted),
                                    16'(want.frame_accepted));
                if (got.error_code != want.error_code)
                    report_mismatch("error_code", 16'(got.error_code),
                                    16'(want.error_code));
                if (got.window_complete != want.window_complete)
                    report_mismatch("window_complete", 16'(got.window_complete),
                                    16'(want.window_complete));
            end
            results_seen++;
            @(negedge clk);
        end
    end

    // Reset, directed table, random frames, drain
    initial
    begin
        clear_parser();
        foreach (pay_bytes[i])
            pay_bytes[i] = 8'h00;
        held_presence     = 8'h00;
        held_breath_phase = 8'h00;
        held_breath_rate  = 16'h0000;
        held_heart_phase  = 8'h00;
        held_heart_rate   = 8'h00;
        seen_mask         = 3'b000;
        window_full       = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            push_request(directed_rows[i].kind, directed_rows[i].data,
                         directed_rows[i].pin, directed_rows[i].acc, directed_rows[i].err);

        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            if (window_full)
            begin
                // a few bytes that the full window ignores, then reopen it
                repeat ($urandom_range(0, 3))
                    push_request(CMD_BYTE, 8'($urandom), 1'b0, 1'b0, ERR_NONE);
                push_request(CMD_START, 8'($urandom), 1'b0, 1'b0, ERR_NONE);
            end
            else if ($urandom_range(0, 49) == 0)
                push_request(CMD_START, 8'($urandom), 1'b0, 1'b0, ERR_NONE);
            else
                send_frame();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sfp_pkg.sv
rtl/sensor_frame_parser.sv
rtl/sensor_frame_parser_checker.sv
tb/sv/tb_sensor_frame_parser.sv
